@@ rtl/best_fit_partition_allocator_defines.svh @@
// Assertion macros for the port-level checker of the partition allocator.
// No dependencies; include by bare file name.
`ifndef BEST_FIT_PARTITION_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_PARTITION_ALLOCATOR_DEFINES_SVH

// Clocked property, disabled while reset is asserted (active low)
`define BFPA_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked during reset
`define BFPA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/bfpa_pkg.sv @@
// Package for the best-fit partition allocator: widths, codes, FSM state
// and the command/status structs between controller and datapath. No deps.
`timescale 1ns / 1ps

package bfpa_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_SLOTS_DEF = 16;
    localparam int SIZE_BITS_DEF = 16;

    // Fixed port widths
    localparam int NUM_W       = 5;
    localparam int SLOT_PORT_W = 4;
    localparam int AMT_W       = 16;
    localparam int STAT_W      = 2;

    localparam logic [NUM_W-1:0] NUM_RESET = 5'd16;

    // Request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_LOADED  = 2'd0,
        ST_GRANTED = 2'd1,
        ST_NOFIT   = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic load_wr;
        logic scan_clr;
        logic scan_rd;
        logic emit;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic is_alloc;
        logic limit_zero;
        logic scan_last;
        logic out_busy;
    } t_dp_stat;

endpackage

@@ rtl/best_fit_partition_allocator.sv @@
// Top level of the best-fit partition allocator: ties controller and
// datapath together. Depends on bfpa_pkg, bfpa_ctrl, bfpa_dp.
//
// Channel   Direction  Handshake               Payload
// input     in         i_valid / o_stall       i_req_type, i_slot, i_amount
// result    out        o_valid / i_stall       o_status, o_granted_slot, o_fragment
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (num_partitions)
//
// A load goes from DECODE to EMIT; an allocate passes SCAN and DRAIN first (neither
// when limit is zero), where limit is num_partitions saturated to MAX_SLOTS: the
// scan reads one slot size per cycle from the single read port of the size memory.
// Reset is synchronous, active low: all partitions free, num_partitions 16.
// One request is in flight at a time; o_stall is high until its result is
// in the output register, which holds while i_stall is high.
`timescale 1ns / 1ps

module best_fit_partition_allocator #(
    parameter int MAX_SLOTS = bfpa_pkg::MAX_SLOTS_DEF,
    parameter int SIZE_BITS = bfpa_pkg::SIZE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_req_type,
    input  logic [bfpa_pkg::SLOT_PORT_W-1:0] i_slot,
    input  logic [bfpa_pkg::AMT_W-1:0]       i_amount,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [bfpa_pkg::STAT_W-1:0]      o_status,
    output logic [bfpa_pkg::SLOT_PORT_W-1:0] o_granted_slot,
    output logic [bfpa_pkg::AMT_W-1:0]       o_fragment,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bfpa_pkg::NUM_W-1:0]       i_cfg_data
);
    import bfpa_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Register writes are always taken
    assign o_cfg_ready = 1'b1;

    bfpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    bfpa_dp #(
        .MAX_SLOTS (MAX_SLOTS),
        .SIZE_BITS (SIZE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_req_type     (i_req_type),
        .i_slot         (i_slot),
        .i_amount       (i_amount),
        .i_cfg_wr       (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_out_stall    (i_stall),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_granted_slot (o_granted_slot),
        .o_fragment     (o_fragment)
    );

endmodule

@@ rtl/bfpa_ctrl.sv @@
// Controller FSM of the partition allocator: sequences capture, load,
// slot scan and result emit. Depends on bfpa_pkg.
`timescale 1ns / 1ps

module bfpa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  bfpa_pkg::t_dp_stat i_stat,
    output logic               o_stall,
    output bfpa_pkg::t_dp_cmd  o_cmd
);
    import bfpa_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_stat.is_alloc) begin
                    o_cmd.load_wr = 1'b1;
                    n_state       = S_EMIT;
                end else begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = i_stat.limit_zero ? S_EMIT : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last compare lands at this edge
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/bfpa_dp.sv @@
// Datapath of the partition allocator: size memory, free bits, config
// register, scan compare and output register. Depends on bfpa_pkg.
`timescale 1ns / 1ps

module bfpa_dp #(
    parameter int MAX_SLOTS = bfpa_pkg::MAX_SLOTS_DEF,
    parameter int SIZE_BITS = bfpa_pkg::SIZE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bfpa_pkg::t_dp_cmd               i_cmd,
    output bfpa_pkg::t_dp_stat              o_stat,
    input  logic                            i_req_type,
    input  logic [bfpa_pkg::SLOT_PORT_W-1:0] i_slot,
    input  logic [bfpa_pkg::AMT_W-1:0]      i_amount,
    input  logic                            i_cfg_wr,
    input  logic [bfpa_pkg::NUM_W-1:0]      i_cfg_data,
    input  logic                            i_out_stall,
    output logic                            o_valid,
    output logic [bfpa_pkg::STAT_W-1:0]     o_status,
    output logic [bfpa_pkg::SLOT_PORT_W-1:0] o_granted_slot,
    output logic [bfpa_pkg::AMT_W-1:0]      o_fragment
);
    import bfpa_pkg::*;

    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

    // Size memory, undefined until loaded
    logic [SIZE_BITS-1:0] r_mem [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] r_free;
    logic [NUM_W-1:0]     r_num;

    // Captured request
    logic                   r_kind;
    logic [SLOT_PORT_W-1:0] r_slot;
    logic [SIZE_BITS-1:0]   r_amt;

    // Scan pipeline
    logic [SLOT_W-1:0]    r_idx;
    logic [SIZE_BITS-1:0] r_rd_size;
    logic                 r_rd_free;
    logic [SLOT_W-1:0]    r_rd_idx;
    logic                 r_cmp_v;

    // Best candidate so far
    logic                 r_found;
    logic [SLOT_W-1:0]    r_best;
    logic [SIZE_BITS-1:0] r_best_size;

    // Output register
    logic                   r_out_valid;
    t_status                r_status;
    logic [SLOT_PORT_W-1:0] r_gslot;
    logic [AMT_W-1:0]       r_frag;

    logic [CNT_W-1:0]  limit;
    logic              slot_ok;
    logic [SLOT_W-1:0] wr_addr;
    logic              fits;
    logic              take;
    logic              grant;

    // Saturate the search range to the table depth
    assign limit   = (32'(r_num) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : CNT_W'(r_num);
    assign slot_ok = (32'(r_slot) < MAX_SLOTS);
    assign wr_addr = SLOT_W'(r_slot);
    assign fits    = r_rd_free && (r_rd_size >= r_amt);
    assign take    = r_cmp_v && fits && (!r_found || (r_rd_size <= r_best_size));
    assign grant   = (r_kind == REQ_ALLOC) && r_found;

    assign o_stat.is_alloc   = (r_kind == REQ_ALLOC);
    assign o_stat.limit_zero = (limit == '0);
    assign o_stat.scan_last  = ((CNT_W'(r_idx) + CNT_W'(1)) == limit);
    assign o_stat.out_busy   = r_out_valid && i_out_stall;

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= NUM_RESET;
        end else if (i_cfg_wr) begin
            r_num <= i_cfg_data;
        end
    end

    // Capture request
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_req_type;
            r_slot <= i_slot;
            r_amt  <= SIZE_BITS'(i_amount);
        end
    end

    // Size memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && slot_ok) begin
            r_mem[wr_addr] <= r_amt;
        end
        if (i_cmd.scan_rd) begin
            r_rd_size <= r_mem[r_idx];
        end
    end

    // Free bits: set by load, cleared by grant
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= '1;
        end else begin
            if (i_cmd.load_wr && slot_ok) begin
                r_free[wr_addr] <= 1'b1;
            end
            if (i_cmd.emit && grant) begin
                r_free[r_best] <= 1'b0;
            end
        end
    end

    // Advance scan index and read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_v <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_cmp_v <= i_cmd.scan_rd;
            if (i_cmd.scan_clr) begin
                r_idx <= '0;
            end else if (i_cmd.scan_rd) begin
                r_idx <= r_idx + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd) begin
            r_rd_free <= r_free[r_idx];
            r_rd_idx  <= r_idx;
        end
    end

    // Keep the smallest fitting slot, later index wins a tie
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.scan_clr) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best      <= r_rd_idx;
            r_best_size <= r_rd_size;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (r_kind == REQ_LOAD) begin
                r_status <= ST_LOADED;
                r_gslot  <= '0;
                r_frag   <= '0;
            end else if (r_found) begin
                r_status <= ST_GRANTED;
                r_gslot  <= SLOT_PORT_W'(r_best);
                r_frag   <= AMT_W'(r_best_size - r_amt);
            end else begin
                r_status <= ST_NOFIT;
                r_gslot  <= '0;
                r_frag   <= '0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_granted_slot = r_gslot;
    assign o_fragment     = r_frag;

endmodule

@@ rtl/bfpa_checker.sv @@
// Port-level checker for the partition allocator, bound to the top level.
// Depends on bfpa_pkg and best_fit_partition_allocator_defines.svh.
`timescale 1ns / 1ps
`include "best_fit_partition_allocator_defines.svh"

module bfpa_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_stall,
    input logic                             o_valid,
    input logic                             i_stall,
    input logic [bfpa_pkg::STAT_W-1:0]      o_status,
    input logic [bfpa_pkg::SLOT_PORT_W-1:0] o_granted_slot,
    input logic [bfpa_pkg::AMT_W-1:0]       o_fragment
);
    import bfpa_pkg::*;

    // Hold a stalled result
    `BFPA_ASSERT_RST(a_out_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_status) && $stable(o_granted_slot) && $stable(o_fragment)), "stalled result changed")

    // Zero slot and fragment unless granted
    `BFPA_ASSERT_RST(a_zero_fields, i_clk, i_rst_n, (o_valid && (o_status != ST_GRANTED)) |-> ((o_granted_slot == '0) && (o_fragment == '0)), "fields nonzero without grant")

    // Block further requests right after one is taken
    `BFPA_ASSERT_RST(a_busy_after_accept, i_clk, i_rst_n, (i_valid && !o_stall) |=> o_stall, "request accepted while busy")

    // Drop any result on reset
    `BFPA_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind best_fit_partition_allocator bfpa_checker u_bfpa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_status       (o_status),
    .o_granted_slot (o_granted_slot),
    .o_fragment     (o_fragment)
);

@@ tb/best_fit_partition_allocator_checker.sv @@
// Checker for the best-fit partition allocator: tracks the partition table,
// predicts each result and compares it with what the block returns.
// Depends on bfpa_pkg.
`timescale 1ns / 1ps

module best_fit_partition_allocator_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_valid,
    input  logic                             i_req_stall,
    input  logic                             i_req_type,
    input  logic [bfpa_pkg::SLOT_PORT_W-1:0] i_slot,
    input  logic [bfpa_pkg::AMT_W-1:0]       i_amount,
    input  logic                             i_res_valid,
    input  logic                             i_res_stall,
    input  logic [bfpa_pkg::STAT_W-1:0]      i_status,
    input  logic [bfpa_pkg::SLOT_PORT_W-1:0] i_granted_slot,
    input  logic [bfpa_pkg::AMT_W-1:0]       i_fragment,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [bfpa_pkg::NUM_W-1:0]       i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);
    import bfpa_pkg::*;

    typedef struct packed {
        t_status                status;
        logic [SLOT_PORT_W-1:0] slot;
        logic [AMT_W-1:0]       fragment;
    } t_alloc_result;

    // Shadow copy of the partition table and the search range
    logic [AMT_W-1:0] part_size [MAX_SLOTS_DEF];
    bit               part_free [MAX_SLOTS_DEF];
    logic [NUM_W-1:0] num_parts;

    t_alloc_result    expected_results [$];
    int               mismatches = 0;

    // Apply one request to the shadow table and return the result it causes
    function automatic t_alloc_result serve_request(logic kind, logic [SLOT_PORT_W-1:0] slot,
                                                    logic [AMT_W-1:0] amount);
        t_alloc_result    res;
        int               limit;
        bit               found;
        int               best;
        logic [AMT_W-1:0] best_size;
        res.status   = ST_LOADED;
        res.slot     = '0;
        res.fragment = '0;
        found        = 1'b0;
        best         = 0;
        best_size    = '0;
        if (kind == REQ_LOAD) begin
            part_size[slot] = amount;
            part_free[slot] = 1'b1;
            return res;
        end
        limit = (num_parts > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : int'(num_parts);
        // smallest free fit; <= lets a later equal size take over
        for (int i = 0; i < limit; i++) begin
            if (part_free[i] && part_size[i] >= amount && (!found || part_size[i] <= best_size)) begin
                found     = 1'b1;
                best      = i;
                best_size = part_size[i];
            end
        end
        if (!found) begin
            res.status = ST_NOFIT;
            return res;
        end
        part_free[best] = 1'b0;
        res.status      = ST_GRANTED;
        res.slot        = best[SLOT_PORT_W-1:0];
        res.fragment    = best_size - amount;
        return res;
    endfunction

    // Watch all three channels on the rising edge
    always @(posedge i_clk) begin
        t_alloc_result want;
        t_alloc_result got;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_SLOTS_DEF; i++) begin
                part_size[i] = '0;
                part_free[i] = 1'b1;
            end
            num_parts = NUM_RESET;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                num_parts = i_cfg_data;
            if (i_req_valid && !i_req_stall)
                expected_results.push_back(serve_request(i_req_type, i_slot, i_amount));
            if (i_res_valid && !i_res_stall) begin
                got.status   = t_status'(i_status);
                got.slot     = i_granted_slot;
                got.fragment = i_fragment;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result status %0d slot %0d fragment %0d",
                                 $time, got.status, got.slot, got.fragment);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: result mismatch: expected status %0d slot %0d ",
                                      "fragment %0d, got status %0d slot %0d fragment %0d"},
                                     $time, want.status, want.slot, want.fragment,
                                     got.status, got.slot, got.fragment);
                    end
                end
            end
        end
        o_fail_count = mismatches;
        o_pending    = expected_results.size();
    end

endmodule

@@ tb/best_fit_partition_allocator_tb.sv @@
// Testbench top for the best-fit partition allocator: clock, reset, request
// and configuration stimulus, watchdog and verdict. Depends on bfpa_pkg,
// best_fit_partition_allocator and best_fit_partition_allocator_checker.
`timescale 1ns / 1ps

module best_fit_partition_allocator_tb;
    import bfpa_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 116;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_valid     = 1'b0;
    logic                   i_req_type  = REQ_LOAD;
    logic [SLOT_PORT_W-1:0] i_slot      = '0;
    logic [AMT_W-1:0]       i_amount    = '0;
    logic                   i_stall     = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic [NUM_W-1:0]       i_cfg_data  = '0;
    logic                   o_stall;
    logic                   o_valid;
    logic [STAT_W-1:0]      o_status;
    logic [SLOT_PORT_W-1:0] o_granted_slot;
    logic [AMT_W-1:0]       o_fragment;
    logic                   o_cfg_ready;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int cur_parts     = NUM_RESET;
    int quiet_cycles  = 0;

    always #2 i_clk = ~i_clk;

    best_fit_partition_allocator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_slot        (i_slot),
        .i_amount      (i_amount),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_granted_slot(o_granted_slot),
        .o_fragment    (o_fragment),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    best_fit_partition_allocator_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_stall   (o_stall),
        .i_req_type    (i_req_type),
        .i_slot        (i_slot),
        .i_amount      (i_amount),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_status      (o_status),
        .i_granted_slot(o_granted_slot),
        .i_fragment    (o_fragment),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Stall the result channel at the rate of the current phase
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // End the run if no channel moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("best_fit_partition_allocator_tb NOT OK");
            $finish;
        end
    end

    // Sizes biased toward a coarse grid so that ties show up often
    function automatic logic [AMT_W-1:0] random_amount();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3, 4, 5: return AMT_W'($urandom_range(0, 15) * 1024);
            default: return AMT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Present one request, with random idle cycles ahead, and hold it until accepted
    task automatic send_request(input logic kind, input logic [SLOT_PORT_W-1:0] slot,
                                input logic [AMT_W-1:0] amount);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid    = 1'b1;
        i_req_type = kind;
        i_slot     = slot;
        i_amount   = amount;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // Hold the sender until every expected result has come back
    task automatic drain_results();
        i_valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    // Write the partition count once the block is idle
    task automatic write_num_partitions(input logic [NUM_W-1:0] value);
        drain_results();
        repeat (8) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        cur_parts   = value;
    endtask

    initial begin
        logic [AMT_W-1:0] load_sizes [MAX_SLOTS_DEF];
        int               phase_parts [PHASES];
        int               eff_parts;
        logic [SLOT_PORT_W-1:0] slot;

        load_sizes  = '{16'd0, 16'hFFFF, 16'd100, 16'd100, 16'd300, 16'd50, 16'd1000, 16'd100,
                        16'd2000, 16'd40000, 16'd7, 16'd300, 16'd12, 16'd64, 16'd4096, 16'd9};
        phase_parts = '{0, 1, 31, 16, 9, 31, 4, $urandom_range(2, 15)};

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fill every slot first so no search ever reads an unwritten size
        for (int i = 0; i < MAX_SLOTS_DEF; i++)
            send_request(REQ_LOAD, SLOT_PORT_W'(i), load_sizes[i]);
        // Tie on 100 goes to the highest slot, zero request takes the empty slot,
        // full-size request fits once and then no longer fits
        send_request(REQ_ALLOC, 4'd0, 16'd100);
        send_request(REQ_ALLOC, 4'd15, 16'd0);
        send_request(REQ_ALLOC, 4'd5, 16'hFFFF);
        send_request(REQ_ALLOC, 4'd0, 16'hFFFF);
        send_request(REQ_ALLOC, 4'd9, 16'd100);
        send_request(REQ_ALLOC, 4'd3, 16'd5000);
        send_request(REQ_ALLOC, 4'd0, 16'd0);

        // Random phases, each with its own partition count and idle pattern
        for (int ph = 0; ph < PHASES; ph++) begin
            write_num_partitions(NUM_W'(phase_parts[ph]));
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 70; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 70; end
                default: begin send_idle_pct = 10; stall_pct = 10; end
            endcase
            eff_parts = (cur_parts > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : cur_parts;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ((ph == 2 || ph == 5) && n % 37 == 36)
                    drain_results();
                if ($urandom_range(0, 1) == 0) begin
                    // mostly refill searched slots, sometimes load outside the range
                    if (eff_parts > 0 && $urandom_range(0, 4) != 0)
                        slot = SLOT_PORT_W'($urandom_range(0, eff_parts - 1));
                    else
                        slot = SLOT_PORT_W'($urandom_range(0, 15));
                    send_request(REQ_LOAD, slot, random_amount());
                end else begin
                    send_request(REQ_ALLOC, SLOT_PORT_W'($urandom_range(0, 15)), random_amount());
                end
            end
        end

        drain_results();
        stall_pct = 0;
        repeat (40) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("best_fit_partition_allocator_tb OK");
        else
            $display("best_fit_partition_allocator_tb NOT OK");
        $finish;
    end

endmodule
